[sv/pod_pkg.sv]
`default_nettype none

package pod_pkg;

    localparam int COORD_BITS_DEF = 32;
    localparam int TOL_BITS       = 16;
    localparam int JOB_DEPTH      = 2;
    localparam int RES_DEPTH      = 4;

    localparam logic [1:0] ORIENT_CW        = 2'd0;
    localparam logic [1:0] ORIENT_CCW       = 2'd1;
    localparam logic [1:0] ORIENT_TOO_SMALL = 2'd2;

    typedef struct packed {
        logic issue;     // job taken from the job queue into the back pipeline
        logic res_push;  // result written into the result queue
    } back_status_t;

endpackage

`default_nettype wire

[sv/pod_front.sv]
`default_nettype none

module pod_front #(
    parameter int COORD_BITS = pod_pkg::COORD_BITS_DEF,
    parameter int JOB_W      = 6 * COORD_BITS + 1
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          accept,
    input  wire logic [COORD_BITS-1:0]         vx,
    input  wire logic [COORD_BITS-1:0]         vy,
    input  wire logic                          last_vertex,
    input  wire logic [pod_pkg::TOL_BITS-1:0]  tie_tolerance,
    output logic                               job_push,
    output logic [JOB_W-1:0]                   job_data
);

    localparam int PW = 2 * COORD_BITS;
    localparam int DW = ((COORD_BITS > pod_pkg::TOL_BITS) ? COORD_BITS : pod_pkg::TOL_BITS) + 1;

    logic [2:0]    cnt_reg, cnt_next;
    logic [1:0]    flags_reg, flags_next;
    logic [PW-1:0] first_reg, prev_reg, corner_reg, before_reg, after_reg;

    logic [PW-1:0] v, fp, corner_new, before_new, after_new, last_real, a_pt, c_pt;
    logic [1:0]    flags_new;
    logic          cnt_zero, closing, y_gt, x_ge, diff_le, take, too_small;
    logic [COORD_BITS:0] diff;
    logic [2:0]    real_cnt;

    assign v        = {vx, vy};
    assign cnt_zero = (cnt_reg == 3'd0);
    assign fp       = cnt_zero ? v : first_reg;
    assign closing  = last_vertex && (v == fp);

    always_comb
    begin
        y_gt    = $signed(vy) > $signed(corner_reg[COORD_BITS-1:0]);
        x_ge    = $signed(vx) >= $signed(corner_reg[PW-1:COORD_BITS]);
        diff    = $signed({corner_reg[COORD_BITS-1], corner_reg[COORD_BITS-1:0]})
                - $signed({vy[COORD_BITS-1], vy});
        // diff is known non-negative whenever it is used
        diff_le = {{(DW-COORD_BITS){1'b0}}, diff[COORD_BITS-1:0]}
               <= {{(DW-pod_pkg::TOL_BITS){1'b0}}, tie_tolerance};
        take    = !closing && (cnt_zero || (!y_gt && !(diff_le && x_ge)));

        flags_new  = take ? {1'b1, cnt_zero} : {1'b0, flags_reg[0]};
        corner_new = take ? v : corner_reg;
        before_new = take ? prev_reg : before_reg;
        after_new  = flags_reg[1] ? v : after_reg;

        // wrap-around neighbors of the corner
        last_real  = closing ? prev_reg : v;
        a_pt       = flags_new[0] ? last_real : before_new;
        c_pt       = flags_new[1] ? fp : after_new;

        real_cnt   = cnt_reg + 3'd1 - {2'b00, closing};
        too_small  = real_cnt < 3'd3;
    end

    assign job_push = accept && last_vertex;
    assign job_data = {too_small, a_pt, corner_new, c_pt};

    always_comb
    begin
        cnt_next   = cnt_reg;
        flags_next = flags_reg;
        if (accept)
        begin
            if (last_vertex)
            begin
                cnt_next   = 3'd0;
                flags_next = 2'b00;
            end
            else
            begin
                flags_next = flags_new;
                if (cnt_reg < 3'd4)
                begin
                    cnt_next = cnt_reg + 3'd1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg   <= 3'd0;
            flags_reg <= 2'b00;
        end
        else
        begin
            cnt_reg   <= cnt_next;
            flags_reg <= flags_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && !last_vertex)
        begin
            first_reg  <= fp;
            prev_reg   <= v;
            corner_reg <= corner_new;
            before_reg <= before_new;
            after_reg  <= after_new;
        end
    end

endmodule

`default_nettype wire

[sv/pod_queue.sv]
`default_nettype none

module pod_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = pod_pkg::JOB_DEPTH
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic             pop,
    output logic [WIDTH-1:0]      rdata,
    output logic                  full,
    output logic                  empty
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [AW-1:0]    wr_ptr_reg, wr_ptr_next, rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]    count_reg, count_next;
    logic             do_push, do_pop;

    assign full    = (count_reg == CW'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rdata   = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= wdata;
        end
    end

endmodule

`default_nettype wire

[sv/pod_back.sv]
`default_nettype none

module pod_back #(
    parameter int COORD_BITS = pod_pkg::COORD_BITS_DEF,
    parameter int JOB_W      = 6 * COORD_BITS + 1
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              job_avail,
    input  wire logic [JOB_W-1:0]  job_data,
    input  wire logic              pop,
    output pod_pkg::back_status_t  status,
    output logic [1:0]             orientation,
    output logic                   empty
);

    localparam int CB = COORD_BITS;
    localparam int DB = CB + 1;
    localparam int MB = 2 * DB;
    localparam int RD = pod_pkg::RES_DEPTH;
    localparam int SW = $clog2(RD + 3);

    logic [CB-1:0] ax, ay, bx, by, cx, cy;
    logic          issue, res_push, res_full;
    logic [1:0]    res;
    logic [SW-1:0] res_count, pending;

    logic                 s1_v_reg, s1_small_reg, s2_v_reg, s2_small_reg;
    logic signed [DB-1:0] d1_reg, d2_reg, d3_reg, d4_reg;
    logic signed [MB-1:0] p1_reg, p2_reg;

    assign ax = job_data[6*CB-1:5*CB];
    assign ay = job_data[5*CB-1:4*CB];
    assign bx = job_data[4*CB-1:3*CB];
    assign by = job_data[3*CB-1:2*CB];
    assign cx = job_data[2*CB-1:CB];
    assign cy = job_data[CB-1:0];

    // issue only when every word in flight has a result slot waiting
    assign pending = res_count + SW'(s1_v_reg) + SW'(s2_v_reg);
    assign issue   = job_avail && (pending < SW'(RD));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_v_reg <= 1'b0;
            s2_v_reg <= 1'b0;
        end
        else
        begin
            s1_v_reg <= issue;
            s2_v_reg <= s1_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_small_reg <= job_data[JOB_W-1];
        d1_reg       <= $signed({bx[CB-1], bx}) - $signed({ax[CB-1], ax});
        d2_reg       <= $signed({cy[CB-1], cy}) - $signed({ay[CB-1], ay});
        d3_reg       <= $signed({by[CB-1], by}) - $signed({ay[CB-1], ay});
        d4_reg       <= $signed({cx[CB-1], cx}) - $signed({ax[CB-1], ax});
        s2_small_reg <= s1_small_reg;
        p1_reg       <= d1_reg * d2_reg;
        p2_reg       <= d3_reg * d4_reg;
    end

    always_comb
    begin
        if (s2_small_reg)
        begin
            res = pod_pkg::ORIENT_TOO_SMALL;
        end
        else if (p1_reg > p2_reg)
        begin
            res = pod_pkg::ORIENT_CW;
        end
        else
        begin
            res = pod_pkg::ORIENT_CCW;
        end
    end

    assign res_push = s2_v_reg;

    pod_queue #(
        .WIDTH (2),
        .DEPTH (RD)
    ) u_res_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (res_push),
        .wdata (res),
        .pop   (pop),
        .rdata (orientation),
        .full  (res_full),
        .empty (empty)
    );

    // occupancy tracked here so the issue check needs no queue internals
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_count <= '0;
        end
        else if (res_push && !(pop && !empty))
        begin
            res_count <= res_count + 1'b1;
        end
        else if (!res_push && pop && !empty)
        begin
            res_count <= res_count - 1'b1;
        end
    end

    assign status.issue    = issue && !res_full;
    assign status.res_push = res_push;

endmodule

`default_nettype wire

[sv/polygon_orientation_detect.sv]
//  channel   direction  handshake                 word
//  vertex    in         push / full               x_coord, y_coord, last_vertex
//  result    out        pop / empty               orientation
//  config    in         cfg_valid / cfg_ready     cfg_data (tie tolerance)
//
//  One vertex is taken every cycle while full is low; per-vertex work is one compare
//  and register update. A polygon's result passes through the job queue, two
//  determinant stages (differences, then two multipliers and a compare) and the result
//  queue before it is on the ports.
//  full rises only when the two-entry job queue is full; the back end draws a job only
//  when the four-entry result queue has room for it and everything ahead of it.
//  Reset clears the polygon tracking, queues and tie tolerance to zero.
`default_nettype none

module polygon_orientation_detect #(
    parameter int COORD_BITS = pod_pkg::COORD_BITS_DEF
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         push,
    output logic                              full,
    input  wire logic [31:0]                  x_coord,
    input  wire logic [31:0]                  y_coord,
    input  wire logic                         last_vertex,
    input  wire logic                         pop,
    output logic                              empty,
    output logic [1:0]                        orientation,
    input  wire logic                         cfg_valid,
    output logic                              cfg_ready,
    input  wire logic [pod_pkg::TOL_BITS-1:0] cfg_data
);

    localparam int JOB_W = 6 * COORD_BITS + 1;

    logic [pod_pkg::TOL_BITS-1:0] tol_reg;
    logic                         in_acc, job_push, job_full, job_empty;
    logic [JOB_W-1:0]             job_wdata, job_rdata;
    pod_pkg::back_status_t        back_status;

    assign cfg_ready = 1'b1;
    assign full      = job_full;
    assign in_acc    = push && !job_full;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tol_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            tol_reg <= cfg_data;
        end
    end

    pod_front #(
        .COORD_BITS (COORD_BITS),
        .JOB_W      (JOB_W)
    ) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .accept        (in_acc),
        .vx            (x_coord[COORD_BITS-1:0]),
        .vy            (y_coord[COORD_BITS-1:0]),
        .last_vertex   (last_vertex),
        .tie_tolerance (tol_reg),
        .job_push      (job_push),
        .job_data      (job_wdata)
    );

    pod_queue #(
        .WIDTH (JOB_W),
        .DEPTH (pod_pkg::JOB_DEPTH)
    ) u_job_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (job_push),
        .wdata (job_wdata),
        .pop   (back_status.issue),
        .rdata (job_rdata),
        .full  (job_full),
        .empty (job_empty)
    );

    pod_back #(
        .COORD_BITS (COORD_BITS),
        .JOB_W      (JOB_W)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .job_avail   (!job_empty),
        .job_data    (job_rdata),
        .pop         (pop),
        .status      (back_status),
        .orientation (orientation),
        .empty       (empty)
    );

`ifndef SYNTHESIS
    a_issue_needs_job: assert property (@(posedge clk) disable iff (!rst_n)
        back_status.issue |-> !job_empty)
        else $error("back end drew from an empty job queue");

    a_job_never_dropped: assert property (@(posedge clk) disable iff (!rst_n)
        job_push |-> !job_full)
        else $error("polygon end accepted while job queue full");

    a_issue_to_result: assert property (@(posedge clk) disable iff (!rst_n)
        back_status.issue |-> ##2 back_status.res_push)
        else $error("issued job did not reach the result queue");
`endif

endmodule

`default_nettype wire

[verif/testbench.sv]
`default_nettype none

module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int IDLE_LIMIT = 4000;
    localparam int TAIL_CYCLES = 8;
    localparam logic signed [31:0] COORD_MIN = 32'sh8000_0000;
    localparam logic signed [31:0] COORD_MAX = 32'sh7fff_ffff;

    // coordinate flavors for random vertices
    localparam int COORDS_FULL = 0;
    localparam int COORDS_SMALL = 1;
    localparam int COORDS_EDGE = 2;
    localparam int COORDS_TINY = 3;

    typedef logic [pod_pkg::TOL_BITS-1:0] tol_t;

    typedef struct packed {
        logic signed [31:0] x;
        logic signed [31:0] y;
    } vertex_t;

    typedef struct packed {
        vertex_t pt;
        logic    last;
    } vertex_word_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic push = 1'b0;
    logic full;
    logic [31:0] x_coord = '0;
    logic [31:0] y_coord = '0;
    logic last_vertex = 1'b0;
    logic pop = 1'b0;
    logic empty;
    logic [1:0] orientation;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    tol_t cfg_data = '0;

    polygon_orientation_detect DUT (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .full       (full),
        .x_coord    (x_coord),
        .y_coord    (y_coord),
        .last_vertex(last_vertex),
        .pop        (pop),
        .empty      (empty),
        .orientation(orientation),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_data   (cfg_data)
    );

    always #2 clk = ~clk;

    // shadow copy of the polygon tracking
    tol_t    tie_tol = '0;
    vertex_t poly_first, poly_prev, corner, corner_before, corner_after;
    int      seen_count = 0;
    bit      corner_is_first = 0;
    bit      after_pending = 0;

    vertex_word_t pending_vertices[$];
    logic [1:0]   orient_exp[$];
    vertex_word_t on_port;

    int  fail_count = 0;
    int  queued_words = 0;
    int  vertices_sent = 0;
    int  n_cw = 0, n_ccw = 0, n_small = 0;
    int  cfg_writes = 0;
    int  send_gap = 0, pop_stall = 0, idle_cycles = 0;
    bit  send_burst = 0, pop_burst = 0;
    logic [1:0] want;

    function automatic bit turns_clockwise(vertex_t a, vertex_t b, vertex_t c);
        logic signed [32:0] dxb, dyb, dxc, dyc;
        logic signed [65:0] lhs, rhs;
        dxb = {b.x[31], b.x} - {a.x[31], a.x};
        dyb = {b.y[31], b.y} - {a.y[31], a.y};
        dxc = {c.x[31], c.x} - {a.x[31], a.x};
        dyc = {c.y[31], c.y} - {a.y[31], a.y};
        lhs = dxb * dyc;
        rhs = dyb * dxc;
        return lhs > rhs;
    endfunction

    task automatic track_vertex(vertex_word_t w);
        bit         closing, take;
        int         n_real;
        vertex_t    v, last_real, pa, pc;
        logic [32:0] ydiff;
        v = w.pt;
        if (seen_count == 0)
            poly_first = v;
        closing = w.last && (v == poly_first);
        if (after_pending)
        begin
            corner_after = v;
            after_pending = 0;
        end
        if (!closing)
        begin
            if (seen_count == 0)
                take = 1;
            else if (v.y > corner.y)
                take = 0;
            else
            begin
                ydiff = {corner.y[31], corner.y} - {v.y[31], v.y};
                take = !(ydiff <= tie_tol && v.x >= corner.x);
            end
            if (take)
            begin
                corner = v;
                corner_before = poly_prev;
                after_pending = 1;
                corner_is_first = (seen_count == 0);
            end
        end
        if (!w.last)
        begin
            poly_prev = v;
            if (seen_count < 4)
                seen_count++;
        end
        else
        begin
            n_real = seen_count + 1 - (closing ? 1 : 0);
            if (n_real < 3)
                orient_exp.push_back(pod_pkg::ORIENT_TOO_SMALL);
            else
            begin
                last_real = closing ? poly_prev : v;
                pa = corner_is_first ? last_real : corner_before;
                pc = after_pending ? poly_first : corner_after;
                orient_exp.push_back(turns_clockwise(pa, corner, pc) ? pod_pkg::ORIENT_CW
                                                                     : pod_pkg::ORIENT_CCW);
            end
            poly_first = '0;
            poly_prev = '0;
            corner = '0;
            corner_before = '0;
            corner_after = '0;
            seen_count = 0;
            corner_is_first = 0;
            after_pending = 0;
        end
    endtask

    function automatic int pick_gap(bit burst);
        int r;
        r = $urandom_range(0, 99);
        if (burst || r < 60)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        if (r < 98)
            return $urandom_range(4, 10);
        return $urandom_range(20, 40);
    endfunction

    function automatic logic signed [31:0] pick_coord(int flavor);
        case (flavor)
            COORDS_SMALL: return $urandom_range(0, 4000) - 2000;
            COORDS_EDGE:  return $urandom_range(0, 1) ? COORD_MAX - $urandom_range(0, 3)
                                                      : COORD_MIN + $urandom_range(0, 3);
            COORDS_TINY:  return $urandom_range(0, 3);
            default:      return $urandom;
        endcase
    endfunction

    task automatic add_vertex(logic signed [31:0] x, logic signed [31:0] y, logic last);
        vertex_word_t w;
        w.pt.x = x;
        w.pt.y = y;
        w.last = last;
        pending_vertices.push_back(w);
        queued_words++;
    endtask

    // close_kind: 0 open, 1 repeat the first vertex, 2 end on a near copy of it
    task automatic queue_polygon(int n_vtx, int close_kind, int flavor, int spread);
        vertex_t v, v0;
        logic signed [31:0] y_base;
        y_base = pick_coord(flavor == COORDS_FULL ? COORDS_SMALL : flavor);
        for (int i = 0; i < n_vtx; i++)
        begin
            v.x = pick_coord(flavor);
            v.y = (spread > 0) ? y_base + $urandom_range(0, spread) : pick_coord(flavor);
            if (i == 0)
                v0 = v;
            add_vertex(v.x, v.y, close_kind == 0 && i == n_vtx - 1);
        end
        if (close_kind == 1)
            add_vertex(v0.x, v0.y, 1'b1);
        else if (close_kind == 2)
            add_vertex(v0.x, v0.y + 1, 1'b1);
    endtask

    task automatic queue_random(int quota);
        int r, n, spread, start;
        start = queued_words;
        while (queued_words - start < quota)
        begin
            r = $urandom_range(0, 99);
            if (r < 8)
            begin
                // noise: random last marks
                n = $urandom_range(1, 6);
                repeat (n)
                    add_vertex(pick_coord($urandom_range(0, 3)), pick_coord($urandom_range(0, 3)),
                               $urandom_range(0, 3) == 0);
            end
            else if (r < 16)
                queue_polygon($urandom_range(1, 2), $urandom_range(0, 2), $urandom_range(0, 3), 0);
            else
            begin
                spread = ($urandom_range(0, 9) < 3) ? $urandom_range(1, 2 * tie_tol + 4) : 0;
                queue_polygon($urandom_range(3, 9), ($urandom_range(0, 9) < 4) ? 1 :
                              ($urandom_range(0, 19) == 0 ? 2 : 0), $urandom_range(0, 3), spread);
            end
        end
        // leave no polygon open across a tolerance change
        queue_polygon(3, 0, COORDS_SMALL, 0);
    endtask

    task automatic write_tolerance(tol_t value);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        tie_tol = value;
        cfg_writes++;
    endtask

    task automatic queue_directed();
        add_vertex(5, 5, 1);                              // lone vertex counts as closed
        add_vertex(0, 0, 0); add_vertex(1, 1, 1);         // two vertices
        add_vertex(0, 0, 0); add_vertex(10, 0, 0); add_vertex(0, 10, 1);   // corner first
        add_vertex(0, 10, 0); add_vertex(10, 0, 0); add_vertex(0, 0, 1);   // corner last
        add_vertex(COORD_MAX, COORD_MAX, 0); add_vertex(COORD_MIN, COORD_MIN, 0);
        add_vertex(COORD_MAX, COORD_MIN, 0); add_vertex(COORD_MAX, COORD_MAX, 1);
        add_vertex(0, 0, 0); add_vertex(1, 1, 0); add_vertex(2, 2, 1);     // collinear
        add_vertex(1, 1, 0); add_vertex(3, 3, 0); add_vertex(1, 1, 1);     // closed, two real
        add_vertex(COORD_MIN, COORD_MAX, 0); add_vertex(COORD_MAX, COORD_MIN, 0);
        add_vertex(COORD_MIN, COORD_MIN, 0); add_vertex(COORD_MAX, COORD_MAX, 1);
    endtask

    task automatic drain();
        while (pending_vertices.size() != 0 || push || orient_exp.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
    endtask

    // vertex driver
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (push && !full)
            begin
                track_vertex(on_port);
                vertices_sent++;
                if ($urandom_range(0, 63) == 0)
                    send_burst = !send_burst;
                send_gap = pick_gap(send_burst);
            end
            if (!(push && full))
            begin
                if (send_gap > 0)
                begin
                    send_gap--;
                    push <= 1'b0;
                end
                else if (pending_vertices.size() != 0)
                begin
                    on_port = pending_vertices.pop_front();
                    x_coord <= on_port.pt.x;
                    y_coord <= on_port.pt.y;
                    last_vertex <= on_port.last;
                    push <= 1'b1;
                end
                else
                    push <= 1'b0;
            end
        end
    end

    // result monitor
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (pop && !empty)
            begin
                if (orient_exp.size() == 0)
                begin
                    $error("unexpected result word: orientation %0d", orientation);
                    fail_count++;
                end
                else
                begin
                    want = orient_exp.pop_front();
                    if (orientation !== want)
                    begin
                        $error("orientation mismatch: expected %0d, actual %0d", want, orientation);
                        fail_count++;
                    end
                    if (want == pod_pkg::ORIENT_CW)
                        n_cw++;
                    else if (want == pod_pkg::ORIENT_CCW)
                        n_ccw++;
                    else
                        n_small++;
                end
            end
            if (pop_stall > 0)
            begin
                pop_stall--;
                pop <= 1'b0;
            end
            else
            begin
                pop <= 1'b1;
                if ($urandom_range(0, 63) == 0)
                    pop_burst = !pop_burst;
                pop_stall = pick_gap(pop_burst);
            end
        end
    end

    // watchdog on cycles where no word moves on any channel
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((push && !full) || (pop && !empty) || (cfg_valid && cfg_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("timeout after %0d idle cycles", idle_cycles);
                $display("polygon_orientation_detect regression: fail");
                $finish;
            end
        end
    end

    initial
    begin
        tol_t tol_plan[6];
        tol_plan[0] = '0;
        tol_plan[1] = '1;
        tol_plan[2] = tol_t'($urandom_range(2, 2000));
        tol_plan[3] = tol_t'(1);
        tol_plan[4] = tol_t'($urandom);
        tol_plan[5] = '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        for (int p = 0; p < 6; p++)
        begin
            write_tolerance(tol_plan[p]);
            if (p == 0)
                queue_directed();
            queue_random(210);
            // sender waits for every outstanding result before the next setting
            drain();
        end
        $display("%0d vertices sent under %0d tolerance settings (0 and 65535 included)",
                 vertices_sent, cfg_writes);
        $display("results checked: %0d clockwise, %0d counterclockwise, %0d too small",
                 n_cw, n_ccw, n_small);
        if (fail_count == 0)
            $display("polygon_orientation_detect regression: pass");
        else
            $display("polygon_orientation_detect regression: fail");
        $finish;
    end

endmodule

`default_nettype wire

[sim.f]
sv/pod_pkg.sv
sv/pod_front.sv
sv/pod_queue.sv
sv/pod_back.sv
sv/polygon_orientation_detect.sv
verif/testbench.sv
